// ===== hdl/grc_pkg.sv =====
// grc_pkg: shared types and constants of the grid ray caster
// no dependencies; used by grc_div, grid_ray_caster_unit, grc_checker and testbench
package grc_pkg;

	localparam int unsigned MAP_SIDE  = 64;
	localparam int unsigned COORD_W   = 6;
	localparam int unsigned MAP_DEPTH = MAP_SIDE * MAP_SIDE;
	localparam int unsigned MAP_AW    = 2 * COORD_W;
	localparam int unsigned KIND_W    = 4;
	localparam int unsigned FRAC_BITS = 16;
	localparam int unsigned DIV_W     = 33;

	localparam logic [KIND_W-1:0] KIND_EMPTY = 4'd0;
	localparam logic [KIND_W-1:0] DOOR_KIND  = 4'd6;

	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_POS_X   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POS_Y   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DIR_X   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PLANE_X = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PLANE_Y = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH   = 3'd6;

	localparam logic [0:0] CMD_WRITE = 1'b0;
	localparam logic [0:0] CMD_CAST  = 1'b1;

	localparam logic [21:0] RST_POS_X   = 22'd131072;
	localparam logic [21:0] RST_POS_Y   = 22'd131072;
	localparam logic [17:0] RST_DIR_X   = 18'h30000;
	localparam logic [17:0] RST_DIR_Y   = 18'd0;
	localparam logic [17:0] RST_PLANE_X = 18'd0;
	localparam logic [17:0] RST_PLANE_Y = 18'd43253;
	localparam logic [12:0] RST_WIDTH   = 13'd640;

	typedef struct packed {
		logic start;
		logic done;
	} div_ctl_t;

	typedef enum logic [10:0] {
		S_CLEAR = 11'b00000000001,
		S_IDLE  = 11'b00000000010,
		S_CAM   = 11'b00000000100,
		S_MUL   = 11'b00000001000,
		S_RAY   = 11'b00000010000,
		S_RX    = 11'b00000100000,
		S_RY    = 11'b00001000000,
		S_SETUP = 11'b00010000000,
		S_STEP  = 11'b00100000000,
		S_CHECK = 11'b01000000000,
		S_DONE  = 11'b10000000000
	} state_t;

endpackage

// ===== hdl/grc_ram.sv =====
// grc_ram: generic single write, single read RAM with registered read
// no dependencies
module grc_ram #(
	parameter int unsigned WIDTH = 4,
	parameter int unsigned DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hdl/grc_div.sv =====
// grc_div: radix-2 restoring divider, one quotient bit per cycle
// depends on grc_pkg for the control struct
module grc_div import grc_pkg::*; #(
	parameter int unsigned W = 33
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] num,
	input  logic [W-1:0] den,
	output div_ctl_t     ctl,
	output logic [W-1:0] quo
);

	localparam int unsigned CNT_W = $clog2(W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     quo_q;
	logic [W-1:0]     den_q;
	logic [W:0]       rem_shift;
	logic [W+1:0]     diff;
	logic             qbit;

	assign rem_shift = {rem_q, quo_q[W-1]};
	assign diff      = {1'b0, rem_shift} - {2'b00, den_q};
	assign qbit      = ~diff[W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[W-1:0] : rem_shift[W-1:0];
			quo_q <= {quo_q[W-2:0], qbit};
		end
	end

	assign ctl.start = start;
	assign ctl.done  = done_q;
	assign quo       = quo_q;

endmodule

// ===== hdl/grid_ray_caster_unit.sv =====
// grid_ray_caster_unit: top level of the grid ray caster
// depends on grc_pkg, grc_ram and grc_div
//
// After reset the block sweeps the 4096-cell map to empty, one cell a cycle, and takes no
// word while it does so; configuration writes are taken at any time. A map write is stored
// in the cycle it is accepted. A cast runs three divisions on one shared one-bit-per-cycle
// divider: the camera position, then, after the multiply and ray states, the x and y
// reciprocals; then a setup state, then a step state and a check state per grid step for
// the map read. A ray that leaves the grid goes from the step state straight to the result.
module grid_ray_caster_unit import grc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 cmd,
	input  logic [11:0]          column,
	input  logic [COORD_W-1:0]   cell_x,
	input  logic [COORD_W-1:0]   cell_y,
	input  logic [KIND_W-1:0]    cell_kind,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [COORD_W-1:0]   hit_x,
	output logic [COORD_W-1:0]   hit_y,
	output logic                 hit_side,
	output logic                 is_door,
	output logic [KIND_W-1:0]    wall_kind,
	output logic [31:0]          final_dist_x,
	output logic [31:0]          final_dist_y,
	output logic [31:0]          step_dist_x,
	output logic [31:0]          step_dist_y,
	output logic                 escaped,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	state_t state_q;

	logic [21:0] pos_x_q, pos_y_q;
	logic [17:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;
	logic [12:0] width_q;

	logic [MAP_AW-1:0] clr_q;

	logic signed [29:0] cam_q;
	logic signed [47:0] prodx_q, prody_q;
	logic signed [32:0] rx_q, ry_q;
	logic [31:0]        dx_q, dy_q, sdx_q, sdy_q;
	logic [COORD_W-1:0] mx_q, my_q;
	logic               negx_q, negy_q, side_q, esc_q;
	logic [KIND_W-1:0]  kind_q;

	logic                 out_valid_q;
	logic [COORD_W-1:0]   hit_x_q, hit_y_q;
	logic                 hit_side_q, is_door_q, escaped_q;
	logic [KIND_W-1:0]    wall_kind_q;
	logic [31:0]          fdx_q, fdy_q, stx_q, sty_q;

	logic                 accept;
	logic                 out_load;
	logic                 div_start;
	logic [DIV_W-1:0]     div_num, div_den, div_quo;
	div_ctl_t             div_ctl;
	logic [31:0]          div_sat;
	logic signed [32:0]   rx_c;
	logic [DIV_W-1:0]     absrx_c, absry_c;
	logic [12:0]          width_eff;

	logic [16:0]          fracx, fracy;
	logic [48:0]          initx, inity;
	logic                 take_x;
	logic [32:0]          sumx, sumy;
	logic [31:0]          sdx_nxt, sdy_nxt;
	logic                 edge_x, edge_y, at_edge;
	logic [COORD_W-1:0]   nx, ny;

	logic                 ram_we, ram_re;
	logic [MAP_AW-1:0]    ram_waddr, ram_raddr;
	logic [KIND_W-1:0]    ram_wdata, ram_rdata;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || !out_stall);
	assign width_eff = (width_q == '0) ? 13'd1 : width_q;

	// ray component and magnitudes
	assign rx_c    = $signed({{15{dir_x_q[17]}}, dir_x_q}) + $signed({prodx_q[47], prodx_q[47:16]});
	assign absrx_c = rx_c[32] ? DIV_W'(-rx_c) : DIV_W'(rx_c);
	assign absry_c = ry_q[32] ? DIV_W'(-ry_q) : DIV_W'(ry_q);
	assign div_sat = (div_quo[DIV_W-1:32] != '0) ? 32'hFFFF_FFFF : div_quo[31:0];

	always_comb begin
		div_start = 1'b0;
		div_num   = {1'b1, 32'd0};
		div_den   = absrx_c;
		unique case (state_q)
			S_IDLE: begin
				div_start = accept && (cmd == CMD_CAST);
				div_num   = {4'd0, column, 17'd0};
				div_den   = {20'd0, width_eff};
			end
			S_RAY: begin
				div_start = 1'b1;
			end
			S_RX: begin
				div_start = div_ctl.done;
				div_den   = absry_c;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	// initial side distances
	assign fracx = negx_q ? {1'b0, pos_x_q[15:0]} : 17'h10000 - {1'b0, pos_x_q[15:0]};
	assign fracy = negy_q ? {1'b0, pos_y_q[15:0]} : 17'h10000 - {1'b0, pos_y_q[15:0]};
	assign initx = fracx * dx_q;
	assign inity = fracy * dy_q;

	// dda step
	assign take_x  = sdx_q < sdy_q;
	assign sumx    = {1'b0, sdx_q} + {1'b0, dx_q};
	assign sumy    = {1'b0, sdy_q} + {1'b0, dy_q};
	assign sdx_nxt = sumx[32] ? 32'hFFFF_FFFF : sumx[31:0];
	assign sdy_nxt = sumy[32] ? 32'hFFFF_FFFF : sumy[31:0];
	assign edge_x  = negx_q ? (mx_q == '0) : (mx_q == COORD_W'(MAP_SIDE - 1));
	assign edge_y  = negy_q ? (my_q == '0) : (my_q == COORD_W'(MAP_SIDE - 1));
	assign at_edge = take_x ? edge_x : edge_y;
	assign nx      = !take_x ? mx_q : (negx_q ? mx_q - 1'b1 : mx_q + 1'b1);
	assign ny      = take_x ? my_q : (negy_q ? my_q - 1'b1 : my_q + 1'b1);

	assign ram_we    = (state_q == S_CLEAR) || (accept && (cmd == CMD_WRITE));
	assign ram_waddr = (state_q == S_CLEAR) ? clr_q : {cell_y, cell_x};
	assign ram_wdata = (state_q == S_CLEAR) ? KIND_EMPTY : cell_kind;
	assign ram_re    = (state_q == S_STEP);
	assign ram_raddr = {ny, nx};

	grc_ram #(
		.WIDTH (KIND_W),
		.DEPTH (MAP_DEPTH)
	) u_map (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	grc_div #(
		.W (DIV_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.ctl    (div_ctl),
		.quo    (div_quo)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q   <= RST_POS_X;
			pos_y_q   <= RST_POS_Y;
			dir_x_q   <= RST_DIR_X;
			dir_y_q   <= RST_DIR_Y;
			plane_x_q <= RST_PLANE_X;
			plane_y_q <= RST_PLANE_Y;
			width_q   <= RST_WIDTH;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_POS_X:   pos_x_q   <= cfg_data[21:0];
				CFG_POS_Y:   pos_y_q   <= cfg_data[21:0];
				CFG_DIR_X:   dir_x_q   <= cfg_data[17:0];
				CFG_DIR_Y:   dir_y_q   <= cfg_data[17:0];
				CFG_PLANE_X: plane_x_q <= cfg_data[17:0];
				CFG_PLANE_Y: plane_y_q <= cfg_data[17:0];
				CFG_WIDTH:   width_q   <= cfg_data[12:0];
				default: begin
				end
			endcase
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == MAP_AW'(MAP_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept && (cmd == CMD_CAST)) begin
						state_q <= S_CAM;
					end
				end
				S_CAM: begin
					if (div_ctl.done) begin
						state_q <= S_MUL;
					end
				end
				S_MUL:   state_q <= S_RAY;
				S_RAY:   state_q <= S_RX;
				S_RX: begin
					if (div_ctl.done) begin
						state_q <= S_RY;
					end
				end
				S_RY: begin
					if (div_ctl.done) begin
						state_q <= S_SETUP;
					end
				end
				S_SETUP: state_q <= S_STEP;
				S_STEP: begin
					state_q <= at_edge ? S_DONE : S_CHECK;
				end
				S_CHECK: begin
					state_q <= (ram_rdata != KIND_EMPTY) ? S_DONE : S_STEP;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_CAM: begin
				cam_q <= $signed({1'b0, div_quo[28:0]}) - $signed(30'h10000);
			end
			S_MUL: begin
				prodx_q <= $signed(plane_x_q) * cam_q;
				prody_q <= $signed(plane_y_q) * cam_q;
			end
			S_RAY: begin
				rx_q <= rx_c;
				ry_q <= $signed({{15{dir_y_q[17]}}, dir_y_q})
					+ $signed({prody_q[47], prody_q[47:16]});
			end
			S_RX: begin
				if (div_ctl.done) begin
					dx_q <= div_sat;
				end
			end
			S_RY: begin
				if (div_ctl.done) begin
					dy_q <= div_sat;
				end
				negx_q <= rx_q[32];
				negy_q <= ry_q[32];
			end
			S_SETUP: begin
				sdx_q  <= initx[48] ? 32'hFFFF_FFFF : initx[47:16];
				sdy_q  <= inity[48] ? 32'hFFFF_FFFF : inity[47:16];
				mx_q   <= pos_x_q[21:16];
				my_q   <= pos_y_q[21:16];
				side_q <= 1'b0;
				kind_q <= KIND_EMPTY;
				esc_q  <= 1'b0;
			end
			S_STEP: begin
				side_q <= !take_x;
				if (take_x) begin
					sdx_q <= sdx_nxt;
				end else begin
					sdy_q <= sdy_nxt;
				end
				if (at_edge) begin
					esc_q <= 1'b1;
				end else begin
					mx_q <= nx;
					my_q <= ny;
				end
			end
			S_CHECK: begin
				kind_q <= ram_rdata;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			hit_x_q     <= mx_q;
			hit_y_q     <= my_q;
			hit_side_q  <= side_q;
			is_door_q   <= (kind_q == DOOR_KIND);
			wall_kind_q <= kind_q;
			fdx_q       <= sdx_q;
			fdy_q       <= sdy_q;
			stx_q       <= dx_q;
			sty_q       <= dy_q;
			escaped_q   <= esc_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign hit_x        = hit_x_q;
	assign hit_y        = hit_y_q;
	assign hit_side     = hit_side_q;
	assign is_door      = is_door_q;
	assign wall_kind    = wall_kind_q;
	assign final_dist_x = fdx_q;
	assign final_dist_y = fdy_q;
	assign step_dist_x  = stx_q;
	assign step_dist_y  = sty_q;
	assign escaped      = escaped_q;

endmodule

// ===== tb/grc_checker.sv =====
// grc_checker: watches the word, config and result channels of the grid ray caster,
// predicts every cast from its own copy of map and camera, and counts mismatches
// depends on grc_pkg
module grc_checker import grc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic                 cmd,
	input  logic [11:0]          column,
	input  logic [COORD_W-1:0]   cell_x,
	input  logic [COORD_W-1:0]   cell_y,
	input  logic [KIND_W-1:0]    cell_kind,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [COORD_W-1:0]   hit_x,
	input  logic [COORD_W-1:0]   hit_y,
	input  logic                 hit_side,
	input  logic                 is_door,
	input  logic [KIND_W-1:0]    wall_kind,
	input  logic [31:0]          final_dist_x,
	input  logic [31:0]          final_dist_y,
	input  logic [31:0]          step_dist_x,
	input  logic [31:0]          step_dist_y,
	input  logic                 escaped,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	output int                   errors,
	output int                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [COORD_W-1:0] hx;
		logic [COORD_W-1:0] hy;
		logic               side;
		logic               door;
		logic [KIND_W-1:0]  kind;
		logic [31:0]        fdx;
		logic [31:0]        fdy;
		logic [31:0]        sdx;
		logic [31:0]        sdy;
		logic               esc;
	} ray_hit_t;

	logic [KIND_W-1:0]  grid [MAP_DEPTH];
	logic [21:0]        cam_pos_x, cam_pos_y;
	logic signed [17:0] cam_dir_x, cam_dir_y, cam_plane_x, cam_plane_y;
	logic [12:0]        cam_width;
	ray_hit_t           hits_due [$];

	function automatic longint clip32(longint v);
		return (v > 64'sh0FFFFFFFF) ? 64'sh0FFFFFFFF : v;
	endfunction

	function automatic longint inv_abs(longint r);
		longint a;
		if (r == 0)
			return 64'sh0FFFFFFFF;
		a = (r < 0) ? -r : r;
		return clip32((64'sd1 << (2 * FRAC_BITS)) / a);
	endfunction

	function automatic ray_hit_t cast_ray(logic [11:0] col);
		longint w, cam, rx, ry, dx, dy, mx, my, sx, sy, sdx, sdy, nx, ny, fr;
		logic [KIND_W-1:0] k;
		logic side, esc, stop;
		ray_hit_t r;
		w = (cam_width == 0) ? 1 : longint'(cam_width);
		cam = ((longint'(col) * 2) << FRAC_BITS) / w - (64'sd1 << FRAC_BITS);
		rx = longint'(cam_dir_x) + ((longint'(cam_plane_x) * cam) >>> FRAC_BITS);
		ry = longint'(cam_dir_y) + ((longint'(cam_plane_y) * cam) >>> FRAC_BITS);
		dx = inv_abs(rx);
		dy = inv_abs(ry);
		mx = longint'(cam_pos_x) >> FRAC_BITS;
		my = longint'(cam_pos_y) >> FRAC_BITS;
		if (rx < 0) begin
			sx = -1;
			fr = longint'(cam_pos_x) - (mx << FRAC_BITS);
		end else begin
			sx = 1;
			fr = ((mx + 1) << FRAC_BITS) - longint'(cam_pos_x);
		end
		sdx = clip32((fr * dx) >> FRAC_BITS);
		if (ry < 0) begin
			sy = -1;
			fr = longint'(cam_pos_y) - (my << FRAC_BITS);
		end else begin
			sy = 1;
			fr = ((my + 1) << FRAC_BITS) - longint'(cam_pos_y);
		end
		sdy = clip32((fr * dy) >> FRAC_BITS);
		side = 0;
		k = KIND_EMPTY;
		esc = 0;
		if (mx >= MAP_SIDE || my >= MAP_SIDE) begin
			esc = 1;
		end else begin
			stop = 0;
			while (!stop) begin
				nx = mx;
				ny = my;
				if (sdx < sdy) begin
					sdx = clip32(sdx + dx);
					nx += sx;
					side = 0;
				end else begin
					sdy = clip32(sdy + dy);
					ny += sy;
					side = 1;
				end
				if (nx < 0 || ny < 0 || nx >= MAP_SIDE || ny >= MAP_SIDE) begin
					esc = 1;
					stop = 1;
				end else begin
					mx = nx;
					my = ny;
					k = grid[my * MAP_SIDE + mx];
					if (k != KIND_EMPTY)
						stop = 1;
				end
			end
		end
		r.hx = mx[COORD_W-1:0];
		r.hy = my[COORD_W-1:0];
		r.side = side;
		r.door = (k == DOOR_KIND);
		r.kind = k;
		r.fdx = sdx[31:0];
		r.fdy = sdy[31:0];
		r.sdx = dx[31:0];
		r.sdy = dy[31:0];
		r.esc = esc;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ray_hit_t want, got;
		if (!arst_n) begin
			for (int i = 0; i < MAP_DEPTH; i++)
				grid[i] = KIND_EMPTY;
			cam_pos_x = RST_POS_X;
			cam_pos_y = RST_POS_Y;
			cam_dir_x = RST_DIR_X;
			cam_dir_y = RST_DIR_Y;
			cam_plane_x = RST_PLANE_X;
			cam_plane_y = RST_PLANE_Y;
			cam_width = RST_WIDTH;
			hits_due.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_POS_X:   cam_pos_x = cfg_data[21:0];
					CFG_POS_Y:   cam_pos_y = cfg_data[21:0];
					CFG_DIR_X:   cam_dir_x = cfg_data[17:0];
					CFG_DIR_Y:   cam_dir_y = cfg_data[17:0];
					CFG_PLANE_X: cam_plane_x = cfg_data[17:0];
					CFG_PLANE_Y: cam_plane_y = cfg_data[17:0];
					CFG_WIDTH:   cam_width = cfg_data[12:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				got = '{hit_x, hit_y, hit_side, is_door, wall_kind, final_dist_x,
					final_dist_y, step_dist_x, step_dist_y, escaped};
				if (hits_due.size() == 0) begin
					if (errors < 10)
						$display("unexpected result word hit=(%0d,%0d)", hit_x, hit_y);
					errors++;
				end else begin
					want = hits_due.pop_front();
					if (got !== want) begin
						if (errors < 10)
							$display({"mismatch exp hit=(%0d,%0d) side=%0d door=%0d kind=%0d ",
								"fd=%h/%h sd=%h/%h esc=%0d | got hit=(%0d,%0d) side=%0d ",
								"door=%0d kind=%0d fd=%h/%h sd=%h/%h esc=%0d"},
								want.hx, want.hy, want.side, want.door, want.kind, want.fdx,
								want.fdy, want.sdx, want.sdy, want.esc, got.hx, got.hy,
								got.side, got.door, got.kind, got.fdx, got.fdy, got.sdx,
								got.sdy, got.esc);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (cmd == CMD_WRITE)
					grid[cell_y * MAP_SIDE + cell_x] = cell_kind;
				else
					hits_due.push_back(cast_ray(column));
			end
			pending = hits_due.size();
		end
	end

endmodule

// ===== tb/testbench.sv =====
// testbench: drives map writes, casts and camera settings into grid_ray_caster_unit
// depends on grc_pkg, grid_ray_caster_unit and grc_checker
module testbench;
	import grc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 6000000;

	logic                 clk, arst_n;
	logic                 in_valid, in_stall, cmd;
	logic [11:0]          column;
	logic [COORD_W-1:0]   cell_x, cell_y, hit_x, hit_y;
	logic [KIND_W-1:0]    cell_kind, wall_kind;
	logic                 out_valid, out_stall, hit_side, is_door, escaped;
	logic [31:0]          final_dist_x, final_dist_y, step_dist_x, step_dist_y;
	logic                 cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;
	int                   errors, pending;
	int                   cycles;

	grid_ray_caster_unit DUT (.*);
	grc_checker u_checker (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(30, 120);
	endfunction

	// receiver: random stalls, plus one long hold-off after 300 results
	initial begin
		int run, taken;
		logic hold;
		bit held;
		out_stall = 0;
		run = 0;
		taken = 0;
		hold = 0;
		held = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				taken++;
			if (!held && taken >= 300) begin
				held = 1;
				out_stall <= 1;
				repeat (3000) @(posedge clk);
				run = 0;
			end
			if (run == 0) begin
				hold = ($urandom_range(0, 3) == 0);
				run = pick_gap() + 1;
			end
			out_stall <= hold;
			run--;
		end
	end

	task automatic send_word(logic c, logic [11:0] col, logic [5:0] x, logic [5:0] y,
		logic [3:0] k);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		cmd <= c;
		column <= col;
		cell_x <= x;
		cell_y <= y;
		cell_kind <= k;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic put_cell(logic [5:0] x, logic [5:0] y, logic [3:0] k);
		send_word(CMD_WRITE, 12'($urandom), x, y, k);
	endtask

	task automatic shoot(logic [11:0] col);
		send_word(CMD_CAST, col, 6'($urandom), 6'($urandom), 4'($urandom));
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val, logic [31:0] keep);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= (val & keep) | ($urandom & ~keep);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
	endtask

	task automatic drain();
		in_valid <= 0;
		do @(posedge clk); while (pending != 0);
		repeat (16) @(posedge clk);
	endtask

	task automatic set_camera(logic [21:0] px, logic [21:0] py, logic [17:0] dx,
		logic [17:0] dy, logic [17:0] plx, logic [17:0] ply, logic [12:0] w);
		cfg_write(CFG_POS_X, px, 32'h3FFFFF);
		cfg_write(CFG_POS_Y, py, 32'h3FFFFF);
		cfg_write(CFG_DIR_X, dx, 32'h3FFFF);
		cfg_write(CFG_DIR_Y, dy, 32'h3FFFF);
		cfg_write(CFG_PLANE_X, plx, 32'h3FFFF);
		cfg_write(CFG_PLANE_Y, ply, 32'h3FFFF);
		cfg_write(CFG_WIDTH, w, 32'h1FFF);
	endtask

	function automatic logic [17:0] rnd_unit();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 18'h20000;
		if (r == 1) return 18'h1FFFF;
		if (r == 2) return 18'd0;
		return 18'($signed($urandom_range(0, 131072)) - 65536);
	endfunction

	initial begin
		int ph;
		arst_n = 0;
		in_valid = 0;
		cmd = CMD_WRITE;
		column = 0;
		cell_x = 0;
		cell_y = 0;
		cell_kind = KIND_EMPTY;
		cfg_valid = 0;
		cfg_index = CFG_POS_X;
		cfg_data = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset camera: door straight ahead, walls at a corner and on an edge
		put_cell(0, 2, DOOR_KIND);
		put_cell(63, 63, 4'd15);
		put_cell(5, 0, 4'd1);
		shoot(12'd320);
		shoot(12'd0);
		shoot(12'd639);
		shoot(12'd4095);
		drain();
		// zero ray: both reciprocals saturate, tie goes to y
		set_camera(22'h28000, 22'h28000, 0, 0, 0, 0, 13'd2);
		shoot(12'd1);
		drain();
		// diagonal from cell center gives side distance ties
		set_camera(22'h18000, 22'h18000, 18'h10000, 18'h10000, 18'h20000, 18'h1FFFF, 13'd0);
		shoot(12'd0);
		shoot(12'd4095);
		drain();
		set_camera(22'h3FFFFF, 22'd0, 18'h20000, 18'h1FFFF, 18'h1FFFF, 18'h20000, 13'h1FFF);
		shoot(12'd0);
		shoot(12'd4095);
		shoot(12'd2048);
		drain();
		set_camera(22'd0, 22'h3FFFFF, 18'h1FFFF, 18'h20000, 18'h20000, 18'h1FFFF, 13'd1);
		shoot(12'd0);
		put_cell(0, 63, 4'd9);
		shoot(12'd1);
		drain();

		for (ph = 0; ph < 12; ph++) begin
			if (ph % 4 == 3)
				set_camera(22'($urandom), 22'($urandom), 18'($urandom), 18'($urandom),
					18'($urandom), 18'($urandom), 13'($urandom));
			else
				set_camera(22'($urandom_range(65536, 63 * 65536 - 1)),
					22'($urandom_range(65536, 63 * 65536 - 1)), rnd_unit(), rnd_unit(),
					rnd_unit(), rnd_unit(), 13'($urandom_range(1, 1024)));
			for (int i = 0; i < 110; i++) begin
				if ($urandom_range(0, 3) == 0)
					put_cell(6'($urandom), 6'($urandom),
						($urandom_range(0, 4) == 0) ? DOOR_KIND : 4'($urandom));
				else if ($urandom_range(0, 2) == 0)
					shoot(12'($urandom));
				else
					shoot(12'($urandom_range(0, 1024)));
			end
			drain();
		end

		in_valid <= 0;
		do @(posedge clk); while (pending != 0);
		repeat (600) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
